FILE: sv/bfbp_pkg.sv
// shared types and constants for the best-fit buffer pool
// no dependencies
`default_nettype none

package bfbp_pkg;

    // default sizes of the pool
    localparam int SLOTS_DEF     = 16;
    localparam int SIZE_BITS_DEF = 32;
    localparam int ID_BITS_DEF   = 32;

    // result codes
    typedef enum logic [2:0] {
        ST_REUSED    = 3'd0,
        ST_GROWN     = 3'd1,
        ST_NEW       = 3'd2,
        ST_FULL      = 3'd3,
        ST_UNLOCKED  = 3'd4,
        ST_NOT_FOUND = 3'd5
    } status_t;

    // update applied to one slot at the end of an item
    typedef enum logic [2:0] {
        CMT_NONE   = 3'd0,
        CMT_UNLOCK = 3'd1,
        CMT_REUSE  = 3'd2,
        CMT_GROW   = 3'd3,
        CMT_NEW    = 3'd4
    } cmt_op_t;

    typedef struct packed {
        cmt_op_t op;
    } commit_t;

    // search record flags handed along the chain
    typedef struct packed {
        logic valid;
        logic fit_ok;
        logic grow_ok;
        logic match_ok;
        logic free_ok;
    } flags_t;

endpackage

`default_nettype wire

FILE: sv/bfbp_cell.sv
// one slot of the buffer pool plus one stage of the search chain
// depends on bfbp_pkg
`default_nettype none

module bfbp_cell #(
    parameter int SLOTS     = bfbp_pkg::SLOTS_DEF,
    parameter int SIZE_BITS = bfbp_pkg::SIZE_BITS_DEF,
    parameter int ID_BITS   = bfbp_pkg::ID_BITS_DEF,
    parameter int CELL_IDX  = 0
) (
    input  wire                                     clk,
    input  wire                                     rst_n,
    // broadcast item operands
    input  wire logic [SIZE_BITS-1:0]               req,
    input  wire logic [31:0]                        want,
    // commit broadcast
    input  wire bfbp_pkg::commit_t                  commit,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] commit_idx,
    input  wire logic [SIZE_BITS-1:0]               commit_bytes,
    input  wire logic [ID_BITS-1:0]                 commit_tag,
    // search record from the previous cell
    input  wire bfbp_pkg::flags_t                   flags_in,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] fit_i_in,
    input  wire logic [SIZE_BITS-1:0]               fit_sz_in,
    input  wire logic [ID_BITS-1:0]                 fit_tag_in,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] grow_i_in,
    input  wire logic [SIZE_BITS-1:0]               grow_sz_in,
    input  wire logic [ID_BITS-1:0]                 grow_tag_in,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] match_i_in,
    input  wire logic [SIZE_BITS-1:0]               match_sz_in,
    input  wire logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] free_i_in,
    // search record to the next cell
    output bfbp_pkg::flags_t                        flags_out,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] fit_i_out,
    output logic [SIZE_BITS-1:0]                    fit_sz_out,
    output logic [ID_BITS-1:0]                      fit_tag_out,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] grow_i_out,
    output logic [SIZE_BITS-1:0]                    grow_sz_out,
    output logic [ID_BITS-1:0]                      grow_tag_out,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] match_i_out,
    output logic [SIZE_BITS-1:0]                    match_sz_out,
    output logic [(SLOTS > 1 ? $clog2(SLOTS) : 1)-1:0] free_i_out
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

    // slot state
    logic                 used_reg, used_next;
    logic                 locked_reg, locked_next;
    logic [SIZE_BITS-1:0] bytes_reg, bytes_next;
    logic [ID_BITS-1:0]   tag_reg, tag_next;

    // outgoing search record
    bfbp_pkg::flags_t     flags_reg, flags_next;
    logic [IDX_W-1:0]     fit_i_reg, fit_i_next;
    logic [SIZE_BITS-1:0] fit_sz_reg, fit_sz_next;
    logic [ID_BITS-1:0]   fit_tag_reg, fit_tag_next;
    logic [IDX_W-1:0]     grow_i_reg, grow_i_next;
    logic [SIZE_BITS-1:0] grow_sz_reg, grow_sz_next;
    logic [ID_BITS-1:0]   grow_tag_reg, grow_tag_next;
    logic [IDX_W-1:0]     match_i_reg, match_i_next;
    logic [SIZE_BITS-1:0] match_sz_reg, match_sz_next;
    logic [IDX_W-1:0]     free_i_reg, free_i_next;

    logic eligible;
    logic fit_hit;
    logic grow_hit;
    logic match_hit;
    logic free_hit;

    // slot update at commit
    always_comb
    begin
        used_next   = used_reg;
        locked_next = locked_reg;
        bytes_next  = bytes_reg;
        tag_next    = tag_reg;
        if (commit_idx == MY_IDX)
        begin
            case (commit.op)
                bfbp_pkg::CMT_UNLOCK:
                begin
                    locked_next = 1'b0;
                end
                bfbp_pkg::CMT_REUSE:
                begin
                    locked_next = 1'b1;
                end
                bfbp_pkg::CMT_GROW:
                begin
                    locked_next = 1'b1;
                    bytes_next  = commit_bytes;
                end
                bfbp_pkg::CMT_NEW:
                begin
                    used_next   = 1'b1;
                    locked_next = 1'b1;
                    bytes_next  = commit_bytes;
                    tag_next    = commit_tag;
                end
                default:
                begin
                    used_next = used_reg;
                end
            endcase
        end
    end

    // compare against the record, strict compares keep the lowest slot on ties
    always_comb
    begin
        eligible  = used_reg && !locked_reg;
        fit_hit   = eligible && (bytes_reg >= req) &&
                    (!flags_in.fit_ok || (bytes_reg < fit_sz_in));
        grow_hit  = eligible && (bytes_reg != '0) && (bytes_reg < req) &&
                    (!flags_in.grow_ok || (bytes_reg > grow_sz_in));
        match_hit = used_reg && !flags_in.match_ok && (64'(tag_reg) == 64'(want));
        free_hit  = !used_reg && !flags_in.free_ok;

        flags_next          = flags_in;
        flags_next.fit_ok   = flags_in.fit_ok | fit_hit;
        flags_next.grow_ok  = flags_in.grow_ok | grow_hit;
        flags_next.match_ok = flags_in.match_ok | match_hit;
        flags_next.free_ok  = flags_in.free_ok | free_hit;

        fit_i_next    = fit_hit ? MY_IDX : fit_i_in;
        fit_sz_next   = fit_hit ? bytes_reg : fit_sz_in;
        fit_tag_next  = fit_hit ? tag_reg : fit_tag_in;
        grow_i_next   = grow_hit ? MY_IDX : grow_i_in;
        grow_sz_next  = grow_hit ? bytes_reg : grow_sz_in;
        grow_tag_next = grow_hit ? tag_reg : grow_tag_in;
        match_i_next  = match_hit ? MY_IDX : match_i_in;
        match_sz_next = match_hit ? bytes_reg : match_sz_in;
        free_i_next   = free_hit ? MY_IDX : free_i_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= 1'b0;
            locked_reg <= 1'b0;
            flags_reg  <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            locked_reg <= locked_next;
            flags_reg  <= flags_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bytes_reg    <= bytes_next;
        tag_reg      <= tag_next;
        fit_i_reg    <= fit_i_next;
        fit_sz_reg   <= fit_sz_next;
        fit_tag_reg  <= fit_tag_next;
        grow_i_reg   <= grow_i_next;
        grow_sz_reg  <= grow_sz_next;
        grow_tag_reg <= grow_tag_next;
        match_i_reg  <= match_i_next;
        match_sz_reg <= match_sz_next;
        free_i_reg   <= free_i_next;
    end

    assign flags_out    = flags_reg;
    assign fit_i_out    = fit_i_reg;
    assign fit_sz_out   = fit_sz_reg;
    assign fit_tag_out  = fit_tag_reg;
    assign grow_i_out   = grow_i_reg;
    assign grow_sz_out  = grow_sz_reg;
    assign grow_tag_out = grow_tag_reg;
    assign match_i_out  = match_i_reg;
    assign match_sz_out = match_sz_reg;
    assign free_i_out   = free_i_reg;

endmodule

`default_nettype wire

FILE: sv/best_fit_buffer_pool_top.sv
// best-fit buffer pool top: command port, id counter, chain of slot cells, commit
// depends on bfbp_pkg and bfbp_cell
// done pulses once the record has passed go_reg, every cell of the chain and the done register
// one item at a time: start is taken only once the record has left the last cell, one cell a cycle
// reset: asynchronous, active low; all slots free and unlocked, id counter zero
`default_nettype none

module best_fit_buffer_pool_top #(
    parameter int SLOTS     = bfbp_pkg::SLOTS_DEF,
    parameter int SIZE_BITS = bfbp_pkg::SIZE_BITS_DEF,
    parameter int ID_BITS   = bfbp_pkg::ID_BITS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    // command side
    input  wire         start,
    output logic        busy,
    input  wire         cmd,
    input  wire  [31:0] req_size,
    input  wire  [31:0] release_id,
    // result side, one cycle strobe, no back-pressure
    output logic        done,
    output logic [2:0]  status,
    output logic [31:0] granted_id,
    output logic [3:0]  slot_index,
    output logic [31:0] slot_size
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // control
    logic busy_reg, busy_next;
    logic go_reg, go_next;
    logic done_reg, done_next;
    logic accept;

    // item operands held for the whole walk
    logic                 cmd_reg;
    logic [SIZE_BITS-1:0] req_reg;
    logic [31:0]          want_reg;
    logic [63:0]          req_wide;
    logic [63:0]          size_max;
    logic [63:0]          req_sat;

    // id counter, wraps past zero to one
    logic [ID_BITS-1:0]   id_cnt_reg, id_cnt_next;
    logic [ID_BITS-1:0]   nid_sum;
    logic [ID_BITS-1:0]   nid;

    // result registers
    bfbp_pkg::status_t    status_reg, status_next;
    logic [31:0]          gid_reg, gid_next;
    logic [3:0]           sidx_reg, sidx_next;
    logic [31:0]          ssize_reg, ssize_next;

    // commit broadcast
    bfbp_pkg::commit_t    commit;
    logic [IDX_W-1:0]     commit_idx;

    // chain of search records, entry 0 is the seed, entry SLOTS the last cell
    bfbp_pkg::flags_t     flg_c      [SLOTS+1];
    logic [IDX_W-1:0]     fit_i_c    [SLOTS+1];
    logic [SIZE_BITS-1:0] fit_sz_c   [SLOTS+1];
    logic [ID_BITS-1:0]   fit_tag_c  [SLOTS+1];
    logic [IDX_W-1:0]     grow_i_c   [SLOTS+1];
    logic [SIZE_BITS-1:0] grow_sz_c  [SLOTS+1];
    logic [ID_BITS-1:0]   grow_tag_c [SLOTS+1];
    logic [IDX_W-1:0]     match_i_c  [SLOTS+1];
    logic [SIZE_BITS-1:0] match_sz_c [SLOTS+1];
    logic [IDX_W-1:0]     free_i_c   [SLOTS+1];
    logic [SLOTS:0]       chain_vld;

    // end-of-chain record widened for output truncation
    bfbp_pkg::flags_t     fin;
    logic                 end_valid;
    logic [63:0]          fit_tag64;
    logic [63:0]          fit_sz64;
    logic [63:0]          grow_tag64;
    logic [63:0]          req64;
    logic [63:0]          nid64;
    logic [63:0]          match_sz64;
    logic [7:0]           fit_i8;
    logic [7:0]           grow_i8;
    logic [7:0]           match_i8;
    logic [7:0]           free_i8;

    assign accept = start && !busy_reg;

    // requests wider than the slot size field saturate
    assign req_wide = 64'(req_size);
    assign size_max = 64'({SIZE_BITS{1'b1}});
    assign req_sat  = (req_wide > size_max) ? size_max : req_wide;

    // seed record enters cell 0 the cycle after accept
    assign flg_c[0]      = '{valid: go_reg, fit_ok: 1'b0, grow_ok: 1'b0,
                             match_ok: 1'b0, free_ok: 1'b0};
    assign fit_i_c[0]    = '0;
    assign fit_sz_c[0]   = '0;
    assign fit_tag_c[0]  = '0;
    assign grow_i_c[0]   = '0;
    assign grow_sz_c[0]  = '0;
    assign grow_tag_c[0] = '0;
    assign match_i_c[0]  = '0;
    assign match_sz_c[0] = '0;
    assign free_i_c[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < SLOTS; g++)
        begin : g_cell
            bfbp_cell #(
                .SLOTS     (SLOTS),
                .SIZE_BITS (SIZE_BITS),
                .ID_BITS   (ID_BITS),
                .CELL_IDX  (g)
            ) u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .req          (req_reg),
                .want         (want_reg),
                .commit       (commit),
                .commit_idx   (commit_idx),
                .commit_bytes (req_reg),
                .commit_tag   (nid),
                .flags_in     (flg_c[g]),
                .fit_i_in     (fit_i_c[g]),
                .fit_sz_in    (fit_sz_c[g]),
                .fit_tag_in   (fit_tag_c[g]),
                .grow_i_in    (grow_i_c[g]),
                .grow_sz_in   (grow_sz_c[g]),
                .grow_tag_in  (grow_tag_c[g]),
                .match_i_in   (match_i_c[g]),
                .match_sz_in  (match_sz_c[g]),
                .free_i_in    (free_i_c[g]),
                .flags_out    (flg_c[g+1]),
                .fit_i_out    (fit_i_c[g+1]),
                .fit_sz_out   (fit_sz_c[g+1]),
                .fit_tag_out  (fit_tag_c[g+1]),
                .grow_i_out   (grow_i_c[g+1]),
                .grow_sz_out  (grow_sz_c[g+1]),
                .grow_tag_out (grow_tag_c[g+1]),
                .match_i_out  (match_i_c[g+1]),
                .match_sz_out (match_sz_c[g+1]),
                .free_i_out   (free_i_c[g+1])
            );
        end
        for (g = 0; g <= SLOTS; g++)
        begin : g_vld
            assign chain_vld[g] = flg_c[g].valid;
        end
    endgenerate

    assign fin       = flg_c[SLOTS];
    assign end_valid = fin.valid;

    // next id, zero is never handed out
    assign nid_sum = id_cnt_reg + ID_BITS'(1);
    assign nid     = (nid_sum == '0) ? ID_BITS'(1) : nid_sum;

    // widen sizes and ids to 64 bits and slot indices to 8 bits, then keep the low bits the ports carry
    assign fit_tag64  = 64'(fit_tag_c[SLOTS]);
    assign fit_sz64   = 64'(fit_sz_c[SLOTS]);
    assign grow_tag64 = 64'(grow_tag_c[SLOTS]);
    assign req64      = 64'(req_reg);
    assign nid64      = 64'(nid);
    assign match_sz64 = 64'(match_sz_c[SLOTS]);
    assign fit_i8     = 8'(fit_i_c[SLOTS]);
    assign grow_i8    = 8'(grow_i_c[SLOTS]);
    assign match_i8   = 8'(match_i_c[SLOTS]);
    assign free_i8    = 8'(free_i_c[SLOTS]);

    // decision at the end of the chain: result plus one slot update
    always_comb
    begin
        commit.op   = bfbp_pkg::CMT_NONE;
        commit_idx  = '0;
        id_cnt_next = id_cnt_reg;
        status_next = status_reg;
        gid_next    = gid_reg;
        sidx_next   = sidx_reg;
        ssize_next  = ssize_reg;
        if (end_valid)
        begin
            if (cmd_reg)
            begin
                if (fin.match_ok)
                begin
                    // unlock of the lowest slot carrying that id
                    commit.op   = bfbp_pkg::CMT_UNLOCK;
                    commit_idx  = match_i_c[SLOTS];
                    status_next = bfbp_pkg::ST_UNLOCKED;
                    gid_next    = want_reg;
                    sidx_next   = match_i8[3:0];
                    ssize_next  = match_sz64[31:0];
                end
                else
                begin
                    status_next = bfbp_pkg::ST_NOT_FOUND;
                    gid_next    = '0;
                    sidx_next   = '0;
                    ssize_next  = '0;
                end
            end
            else if (fin.fit_ok)
            begin
                // smallest used, unlocked slot that already fits
                commit.op   = bfbp_pkg::CMT_REUSE;
                commit_idx  = fit_i_c[SLOTS];
                status_next = bfbp_pkg::ST_REUSED;
                gid_next    = fit_tag64[31:0];
                sidx_next   = fit_i8[3:0];
                ssize_next  = fit_sz64[31:0];
            end
            else if (fin.grow_ok)
            begin
                // largest used, unlocked undersized slot of nonzero size, grown to the request
                commit.op   = bfbp_pkg::CMT_GROW;
                commit_idx  = grow_i_c[SLOTS];
                status_next = bfbp_pkg::ST_GROWN;
                gid_next    = grow_tag64[31:0];
                sidx_next   = grow_i8[3:0];
                ssize_next  = req64[31:0];
            end
            else if (fin.free_ok)
            begin
                // open the lowest unused slot with a fresh id
                commit.op   = bfbp_pkg::CMT_NEW;
                commit_idx  = free_i_c[SLOTS];
                id_cnt_next = nid;
                status_next = bfbp_pkg::ST_NEW;
                gid_next    = nid64[31:0];
                sidx_next   = free_i8[3:0];
                ssize_next  = req64[31:0];
            end
            else
            begin
                // table full, counter holds
                status_next = bfbp_pkg::ST_FULL;
                gid_next    = '0;
                sidx_next   = '0;
                ssize_next  = '0;
            end
        end
    end

    // busy from accept until the result is registered
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (end_valid)
        begin
            busy_next = 1'b0;
        end
        go_next   = accept;
        done_next = end_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            go_reg     <= 1'b0;
            done_reg   <= 1'b0;
            id_cnt_reg <= '0;
        end
        else
        begin
            busy_reg   <= busy_next;
            go_reg     <= go_next;
            done_reg   <= done_next;
            id_cnt_reg <= id_cnt_next;
        end
    end

    // operands and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            req_reg  <= req_sat[SIZE_BITS-1:0];
            want_reg <= release_id;
        end
        status_reg <= status_next;
        gid_reg    <= gid_next;
        sidx_reg   <= sidx_next;
        ssize_reg  <= ssize_next;
    end

    assign busy       = busy_reg;
    assign done       = done_reg;
    assign status     = status_reg;
    assign granted_id = gid_reg;
    assign slot_index = sidx_reg;
    assign slot_size  = ssize_reg;

    // at most one search record in flight
    a_one_record: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(chain_vld))
        else $error("more than one record in the chain");

    // the chain only runs while an item is being worked on
    a_chain_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (chain_vld != '0) |-> busy_reg)
        else $error("chain active while idle");

    // an accepted item keeps the block busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg && go_reg)
        else $error("accept did not start a walk");

    // result strobe only once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg && $past(end_valid))
        else $error("result strobe out of place");

    // a new buffer never gets id zero
    a_new_id: assert property (@(posedge clk) disable iff (!rst_n)
        (end_valid && commit.op == bfbp_pkg::CMT_NEW) |-> (nid != '0))
        else $error("new buffer got id zero");

endmodule

`default_nettype wire
